// ===== rtl/core/itf_pkg.sv =====
// Shared types, constants and helpers of the integer-to-text formatter.
// No dependencies; used by itf_ctrl, itf_datapath and integer_to_text_formatter.
package itf_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int unsigned ND_W       = 5;
  localparam int unsigned FIELD_W    = 7;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned BITS_PER_STEP = 2;

  localparam logic [FIELD_W-1:0] MAX_WIDTH  = 7'd64;
  localparam logic [CNT_W-1:0]   CONV_LAST  = CNT_W'(VALUE_W / BITS_PER_STEP - 1);
  localparam logic [ND_W-1:0]    ND_FULL    = ND_W'(NUM_DIGITS);

  localparam logic [1:0] FUNC_UDEC = 2'd0;
  localparam logic [1:0] FUNC_SDEC = 2'd1;
  localparam logic [1:0] FUNC_HEXL = 2'd2;
  localparam logic [1:0] FUNC_HEXU = 2'd3;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_A_LO  = 8'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SIGN_A,
    ST_PAD,
    ST_SIGN_B,
    ST_DIGS
  } state_t;

  typedef enum logic [1:0] {
    EMIT_SIGN,
    EMIT_PAD,
    EMIT_DIGIT
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  conv_step;
    logic  shift_digit;
    logic  set_pad;
    logic  dec_pad;
    logic  emit;
    emit_t emit_kind;
    logic  emit_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_hex;
    logic conv_done;
    logic norm_done;
    logic neg;
    logic zpad;
    logic pad_done;
    logic digit_last;
    logic slot_free;
  } dp_stat_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d,
                                            input logic upper);
    logic [7:0] base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, d};
    end else begin
      digit_char = base + {4'd0, d - 4'd10};
    end
  endfunction

endpackage

// ===== rtl/core/itf_ctrl.sv =====
// Sequencer of the integer-to-text formatter: walks convert, normalise and emit phases.
// Depends on itf_pkg; drives the datapath through ctl_cmd_t and reads dp_stat_t.
module itf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  itf_pkg::dp_stat_t stat,
  output itf_pkg::ctl_cmd_t cmd
);

  itf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.in_hex ? itf_pkg::ST_NORM : itf_pkg::ST_CONV;
        end
      end
      itf_pkg::ST_CONV: begin
        if (stat.conv_done) state_nxt = itf_pkg::ST_NORM;
      end
      itf_pkg::ST_NORM: begin
        if (stat.norm_done) begin
          state_nxt = (stat.neg && stat.zpad) ? itf_pkg::ST_SIGN_A : itf_pkg::ST_PAD;
        end
      end
      itf_pkg::ST_SIGN_A: begin
        if (stat.slot_free) state_nxt = itf_pkg::ST_PAD;
      end
      itf_pkg::ST_PAD: begin
        if (stat.pad_done) begin
          state_nxt = (stat.neg && !stat.zpad) ? itf_pkg::ST_SIGN_B : itf_pkg::ST_DIGS;
        end
      end
      itf_pkg::ST_SIGN_B: begin
        if (stat.slot_free) state_nxt = itf_pkg::ST_DIGS;
      end
      itf_pkg::ST_DIGS: begin
        if (stat.slot_free && stat.digit_last) state_nxt = itf_pkg::ST_IDLE;
      end
      default: state_nxt = itf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.emit_kind = itf_pkg::EMIT_PAD;
    in_stall      = (state_r != itf_pkg::ST_IDLE);
    unique case (state_r) inside
      itf_pkg::ST_IDLE: begin
        cmd.load = in_valid;
      end
      itf_pkg::ST_CONV: begin
        cmd.conv_step = 1'b1;
      end
      itf_pkg::ST_NORM: begin
        cmd.shift_digit = !stat.norm_done;
        cmd.set_pad     = stat.norm_done;
      end
      itf_pkg::ST_SIGN_A, itf_pkg::ST_SIGN_B: begin
        cmd.emit      = stat.slot_free;
        cmd.emit_kind = itf_pkg::EMIT_SIGN;
      end
      itf_pkg::ST_PAD: begin
        cmd.emit      = stat.slot_free && !stat.pad_done;
        cmd.dec_pad   = stat.slot_free && !stat.pad_done;
        cmd.emit_kind = itf_pkg::EMIT_PAD;
      end
      itf_pkg::ST_DIGS: begin
        cmd.emit        = stat.slot_free;
        cmd.shift_digit = stat.slot_free;
        cmd.emit_kind   = itf_pkg::EMIT_DIGIT;
        cmd.emit_last   = stat.digit_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/itf_datapath.sv =====
// Datapath of the integer-to-text formatter: magnitude, BCD conversion, digit
// register, pad counter and output register. Depends on itf_pkg.
module itf_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [63:0]       in_value,
  input  logic [1:0]        in_func,
  input  logic [6:0]        in_min_width,
  input  logic              in_zero_pad,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        out_char_out,
  output logic              out_last,
  input  itf_pkg::ctl_cmd_t cmd,
  output itf_pkg::dp_stat_t stat
);

  logic [itf_pkg::VALUE_W-1:0] bin_r, bin_nxt;
  logic [itf_pkg::BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [itf_pkg::CNT_W-1:0]   cnt_r;
  logic [itf_pkg::ND_W-1:0]    nd_r;
  logic [itf_pkg::FIELD_W-1:0] width_r;
  logic [itf_pkg::FIELD_W-1:0] pad_r;
  logic                        neg_r;
  logic                        zpad_r;
  logic                        upper_r;
  logic                        out_valid_r;
  logic [7:0]                  out_char_r;
  logic                        out_last_r;

  logic                        load_neg;
  logic [itf_pkg::VALUE_W-1:0] load_mag;
  logic [itf_pkg::FIELD_W-1:0] total;
  logic [itf_pkg::DIGIT_W-1:0] top_digit;
  logic [7:0]                  emit_char;
  logic                        slot_free;

  assign load_neg  = (in_func == itf_pkg::FUNC_SDEC) && in_value[63];
  assign load_mag  = load_neg ? (64'd0 - in_value) : in_value;
  assign top_digit = bcd_r[itf_pkg::BCD_W-1 -: itf_pkg::DIGIT_W];
  assign total     = itf_pkg::FIELD_W'(nd_r) + itf_pkg::FIELD_W'(neg_r);
  assign slot_free = !out_valid_r || !out_stall;

  // Double dabble, two input bits a cycle.
  always_comb begin
    bcd_nxt = bcd_r;
    bin_nxt = bin_r;
    for (int s = 0; s < itf_pkg::BITS_PER_STEP; s++) begin
      for (int i = 0; i < itf_pkg::NUM_DIGITS; i++) begin
        if (bcd_nxt[i*itf_pkg::DIGIT_W +: itf_pkg::DIGIT_W] >= 4'd5) begin
          bcd_nxt[i*itf_pkg::DIGIT_W +: itf_pkg::DIGIT_W] =
            bcd_nxt[i*itf_pkg::DIGIT_W +: itf_pkg::DIGIT_W] + 4'd3;
        end
      end
      bcd_nxt = {bcd_nxt[itf_pkg::BCD_W-2:0], bin_nxt[itf_pkg::VALUE_W-1]};
      bin_nxt = {bin_nxt[itf_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  always_comb begin
    case (cmd.emit_kind)
      itf_pkg::EMIT_SIGN:  emit_char = itf_pkg::CH_MINUS;
      itf_pkg::EMIT_PAD:   emit_char = zpad_r ? itf_pkg::CH_ZERO : itf_pkg::CH_SPACE;
      itf_pkg::EMIT_DIGIT: emit_char = itf_pkg::digit_char(top_digit, upper_r);
      default:             emit_char = itf_pkg::CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r   <= load_neg;
      zpad_r  <= in_zero_pad;
      upper_r <= (in_func == itf_pkg::FUNC_HEXU);
      width_r <= (in_min_width > itf_pkg::MAX_WIDTH) ? itf_pkg::MAX_WIDTH : in_min_width;
      cnt_r   <= '0;
      nd_r    <= itf_pkg::ND_FULL;
      if (in_func[1]) begin
        bcd_r <= {{(itf_pkg::BCD_W - itf_pkg::VALUE_W){1'b0}}, load_mag};
      end else begin
        bcd_r <= '0;
        bin_r <= load_mag;
      end
    end else if (cmd.conv_step) begin
      bcd_r <= bcd_nxt;
      bin_r <= bin_nxt;
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.shift_digit) begin
      bcd_r <= {bcd_r[itf_pkg::BCD_W-itf_pkg::DIGIT_W-1:0], {itf_pkg::DIGIT_W{1'b0}}};
      nd_r  <= nd_r - 1'b1;
    end
    if (cmd.set_pad) begin
      pad_r <= (width_r > total) ? (width_r - total) : '0;
    end else if (cmd.dec_pad) begin
      pad_r <= pad_r - 1'b1;
    end
    if (cmd.emit) begin
      out_char_r <= emit_char;
      out_last_r <= cmd.emit_last;
    end
  end

  // Hold the result until the far side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

  assign stat.in_hex     = in_func[1];
  assign stat.conv_done  = (cnt_r == itf_pkg::CONV_LAST);
  assign stat.norm_done  = (nd_r == 5'd1) || (top_digit != 4'd0);
  assign stat.neg        = neg_r;
  assign stat.zpad       = zpad_r;
  assign stat.pad_done   = (pad_r == '0);
  assign stat.digit_last = (nd_r == 5'd1);
  assign stat.slot_free  = slot_free;

endmodule

// ===== rtl/core/integer_to_text_formatter.sv =====
// Top level of the integer-to-text formatter.
// Depends on itf_pkg, itf_ctrl and itf_datapath.

// Formats one 64-bit value per input transfer as ASCII text, one character per
// output transfer, with out_last set on the final character. in_func selects
// unsigned decimal, signed decimal (two's complement, most negative value safe),
// lower-case hex or upper-case hex. in_min_width is the minimum field length with
// the sign counted, saturating at 64; in_zero_pad puts '0' after the sign, else
// spaces go before it. Zero prints as a single '0'. One number at a time: the
// input stalls from acceptance until the last character has entered the output
// register, and the next number is taken while that character still waits.
// A decimal number is loaded, converted from binary to BCD two bits a cycle,
// then normalised by shifting out leading zero digits, the padding being sized
// as normalisation ends. The characters then go out one per cycle while the
// output does not stall, with a pause as the padding phase ends. Hex skips the
// conversion and normalises from 20 nibble slots.
module integer_to_text_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_value,
  input  logic [1:0]  in_func,
  input  logic [6:0]  in_min_width,
  input  logic        in_zero_pad,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char_out,
  output logic        out_last
);

  itf_pkg::ctl_cmd_t cmd;
  itf_pkg::dp_stat_t stat;

  // Sequencer: decides each cycle what the datapath does.
  itf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: holds the number, its digits, the pad count and the output register.
  itf_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_value     (in_value),
    .in_func      (in_func),
    .in_min_width (in_min_width),
    .in_zero_pad  (in_zero_pad),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_char_out (out_char_out),
    .out_last     (out_last),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule
